// ----- src/fedl_pkg.sv -----
// Shared types and constants for the feedback echo delay line.
package fedl_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int LEN_W      = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int GAIN_FRAC  = 12;
	localparam int PROD_W     = SAMPLE_W + GAIN_W;
	localparam int ECHO_W     = PROD_W - GAIN_FRAC;
	localparam int SUM_W      = ECHO_W + 1;

	localparam int OUT_DEPTH  = 8;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [GAIN_W-1:0]   gain_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ECHO_W-1:0]   echo_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	localparam cfg_idx_t REG_DELAY_LENGTH = 1'b0;
	localparam cfg_idx_t REG_DECAY_GAIN   = 1'b1;

	localparam sample_t SAT_MAX = 16'sh7fff;
	localparam sample_t SAT_MIN = 16'sh8000;

endpackage

// ----- src/fedl_in_if.sv -----
// Input sample channel: valid, ready and one signed sample.
interface fedl_in_if;
	import fedl_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// ----- src/fedl_out_if.sv -----
// Result sample channel: valid, ready and one signed sample.
interface fedl_out_if;
	import fedl_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ----- src/fedl_out_fifo.sv -----
// Small result queue that decouples the pipeline from the receiver.
module fedl_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  fedl_pkg::sample_t              push_data,
	output logic [fedl_pkg::OUT_CNT_W-1:0] level,
	fedl_out_if.source                     result_ch
);
	import fedl_pkg::*;

	sample_t                fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]   wr_ptr_q;
	logic [OUT_PTR_W-1:0]   rd_ptr_q;
	logic [OUT_CNT_W-1:0]   cnt_q;
	logic                   pop;

	assign pop                  = result_ch.valid && result_ch.ready;
	assign result_ch.valid      = (cnt_q != '0);
	assign result_ch.sample_out = fifo_q[rd_ptr_q];
	assign level                = cnt_q;

	// The producer only pushes when a slot has been reserved for the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ----- src/feedback_echo_delay_line.sv -----
// Feedback comb filter (echo) on a stream of signed 16-bit audio samples.
//
// Words arrive on sample_ch and leave on result_ch, both valid/ready channels
// that transfer a word at a clock edge where valid and ready are both high.
// Each input word yields exactly one result word: the input plus the stored
// past output, scaled by decay_gain (Q3.12) and rounded half away from zero,
// saturated to 16 bits. That result is also written back into the ring.
// Registers are written through cfg_wen/cfg_index/cfg_wdata while idle, a rule
// for the user that the block does not enforce: index 0 is the delay length in
// samples, index 1 is the decay gain. Throughput is one word per cycle unless
// the block stalls. With a delay length of one, a word reads the entry its
// predecessor is still computing; the read-multiply-add-write loop spans two
// registers, so each word then waits until its predecessor has moved on.
// Results land in an eight-word queue; sample_ch keeps accepting while the
// receiver stalls until every queue slot is claimed by words in flight.
// Reset clears the ring position, the decay gain and the pipeline at once and
// sets the delay length to one. The ring memory itself is not swept: a fill
// mark tracks the prefix of entries ever written, and entries past it read as
// zero, so the block is ready as soon as reset is released.
module feedback_echo_delay_line #(
	parameter int MAX_DELAY = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fedl_in_if.sink                         sample_ch,
	fedl_out_if.source                      result_ch,
	input  logic                            cfg_wen,
	input  logic [fedl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fedl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fedl_pkg::*;

	// Address width of the ring and width of lengths compared against it.
	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int MW = $clog2(MAX_DELAY + 1);
	localparam int CW = (MW > LEN_W) ? MW : LEN_W;
	localparam logic [CW-1:0] MAX_LEN = CW'(MAX_DELAY);
	localparam logic [CW-1:0] ONE_LEN = CW'(1);
	localparam prod_t RND_POS = prod_t'(2 ** (GAIN_FRAC - 1));
	localparam prod_t RND_NEG = prod_t'(2 ** (GAIN_FRAC - 1) - 1);

	// Configuration: the length is stored already clamped to 1..MAX_DELAY.
	logic [CW-1:0] len_q;
	gain_t         gain_q;
	logic [CW-1:0] cfg_len;
	logic [CW-1:0] cfg_len_clamped;

	assign cfg_len = CW'(cfg_wdata[LEN_W-1:0]);

	always_comb begin
		if (cfg_len == '0) begin
			cfg_len_clamped = ONE_LEN;
		end else if (cfg_len > MAX_LEN) begin
			cfg_len_clamped = MAX_LEN;
		end else begin
			cfg_len_clamped = cfg_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= ONE_LEN;
			gain_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DELAY_LENGTH: len_q  <= cfg_len_clamped;
				REG_DECAY_GAIN:   gain_q <= gain_t'(cfg_wdata[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	// Ring position. A position left beyond a shortened ring restarts at zero.
	logic [AW-1:0] pos_q;
	logic [AW-1:0] issue_pos;
	logic [AW-1:0] next_pos;
	logic [CW-1:0] inc_len;
	logic [CW-1:0] fill_q;
	logic          issue_ok;

	assign issue_pos = (CW'(pos_q) >= len_q) ? '0 : pos_q;
	assign inc_len   = CW'(issue_pos) + ONE_LEN;
	assign next_pos  = (inc_len >= len_q) ? '0 : inc_len[AW-1:0];

	// Writes always follow the ring from zero upward, so the entries ever
	// written form a prefix. The fill mark counts positions already issued;
	// an issued position is written by its own word when it reaches the third stage.
	assign issue_ok  = (CW'(issue_pos) < fill_q);

	// Pipeline control.
	logic                 v_s1, v_s2, v_s3, wv_q;
	logic [AW-1:0]        addr_s1, addr_s2, addr_s3, waddr_q;
	logic                 hazard;
	logic                 accept;
	logic [OUT_CNT_W-1:0] fifo_level;
	logic [OUT_CNT_W-1:0] occupancy;

	// The word one stage ahead has not computed its result yet, so a word
	// that targets the same entry waits until that word has moved on and is then forwarded.
	assign hazard    = v_s1 && (addr_s1 == issue_pos);
	assign occupancy = fifo_level + OUT_CNT_W'(v_s1) + OUT_CNT_W'(v_s2)
		+ OUT_CNT_W'(v_s3);
	assign sample_ch.ready = !hazard && (occupancy < OUT_CNT_W'(OUT_DEPTH));
	assign accept          = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			wv_q   <= 1'b0;
			pos_q  <= '0;
			fill_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			wv_q <= v_s3;
			if (accept) begin
				pos_q <= next_pos;
				if (CW'(issue_pos) == fill_q) begin
					fill_q <= fill_q + ONE_LEN;
				end
			end
		end
	end

	// Ring memory: read at acceptance, written from the third stage.
	sample_t ring_mem [MAX_DELAY];
	sample_t rd_s1;
	sample_t y_s3;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= ring_mem[issue_pos];
		end
		if (v_s3) begin
			ring_mem[addr_s3] <= y_s3;
		end
	end

	// Stage 1: pick the freshest copy of the past output, then multiply.
	// The third stage holds a result not yet in memory, and the last write
	// landed on the same edge as this read, so both are forwarded.
	sample_t x_s1;
	logic    ok_s1;
	sample_t wdata_q;
	sample_t past_s1;

	always_comb begin
		if (v_s3 && (addr_s3 == addr_s1)) begin
			past_s1 = y_s3;
		end else if (wv_q && (waddr_q == addr_s1)) begin
			past_s1 = wdata_q;
		end else if (ok_s1) begin
			past_s1 = rd_s1;
		end else begin
			past_s1 = '0;
		end
	end

	// Stage 2: round half away from zero, add the input and saturate.
	// For a negative product, adding one half less and shifting arithmetically
	// gives the same magnitude as rounding the absolute value.
	prod_t   prod_s2;
	sample_t x_s2;
	prod_t   rnd_sum;
	echo_t   echo_s2;
	sum_t    sum_s2;
	sample_t y_s2;

	assign rnd_sum = prod_s2 + (prod_s2[PROD_W-1] ? RND_NEG : RND_POS);
	assign echo_s2 = echo_t'(rnd_sum[PROD_W-1:GAIN_FRAC]);
	assign sum_s2  = SUM_W'(x_s2) + SUM_W'(echo_s2);

	always_comb begin
		if (sum_s2 > SUM_W'(SAT_MAX)) begin
			y_s2 = SAT_MAX;
		end else if (sum_s2 < SUM_W'(SAT_MIN)) begin
			y_s2 = SAT_MIN;
		end else begin
			y_s2 = sample_t'(sum_s2[SAMPLE_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= issue_pos;
			x_s1    <= sample_ch.sample_in;
			ok_s1   <= issue_ok;
		end
		addr_s2 <= addr_s1;
		x_s2    <= x_s1;
		prod_s2 <= past_s1 * gain_q;
		addr_s3 <= addr_s2;
		y_s3    <= y_s2;
		waddr_q <= addr_s3;
		wdata_q <= y_s3;
	end

	// Stage 3 pushes the result into the queue as it is written back.
	fedl_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (y_s3),
		.level     (fifo_level),
		.result_ch (result_ch)
	);
endmodule

// ----- src/fedl_checker.sv -----
// Port-level checks on the echo delay line, bound to its top level.
module fedl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fedl_pkg::SAMPLE_W-1:0] sample_out
);
	import fedl_pkg::*;

	logic [OUT_CNT_W:0] pending_q;
	logic               in_acc;
	logic               out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + (OUT_CNT_W + 1)'(1);
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - (OUT_CNT_W + 1)'(1);
		end
	end

	// A result is only offered for a word that was taken in.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("result offered with no word outstanding");

	// Words in flight never exceed the result queue's slots.
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= (OUT_CNT_W + 1)'(OUT_DEPTH))
		else $error("more words in flight than queue slots");

	// An accepted word leads to a result on offer once it has passed the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##4 out_valid)
		else $error("result not offered four cycles after acceptance");

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
		else $error("stalled result dropped or changed");
endmodule

bind feedback_echo_delay_line fedl_checker u_fedl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.sample_out (result_ch.sample_out)
);
